>>> rtl/mmn_pkg.sv
// Shared constants, codes and types of the masked min-max axis normalizer.
// No dependencies; every other file of the block imports this package.
package mmn_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int FRACTION_BITS = 16;
   localparam int CHANNELS      = 3;

   // divider runs FRACTION_BITS + 1 steps; the extra bit rounds to nearest
   localparam int DIV_STEPS = FRACTION_BITS + 1;
   localparam int CNT_W     = $clog2(FRACTION_BITS + 2);
   localparam int WIDE_W    = (VALUE_WIDTH + 1 > FRACTION_BITS + 1) ?
                              VALUE_WIDTH + 1 : FRACTION_BITS + 1;

   localparam logic [1:0] KIND_RAW   = 2'd0;
   localparam logic [1:0] KIND_SHIFT = 2'd1;
   localparam logic [1:0] KIND_NORM  = 2'd2;

   localparam logic MODE_MEASURE = 1'b0;
   localparam logic MODE_APPLY   = 1'b1;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [VALUE_WIDTH:0]   result_type;
   typedef logic [1:0]                    kind_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;
      logic measure;
      logic prep;
      logic step;
      logic finish;
   } dp_cmd_type;

endpackage

>>> rtl/mmn_if.sv
// Valid/ready channel interfaces: pixel requests, results, config writes.
// Depends on mmn_pkg.
interface mmn_req_if import mmn_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      mode;
   logic      first;
   value_type x_value;
   value_type y_value;
   value_type z_value;
   logic      x_finite;
   logic      y_finite;
   logic      z_finite;

   modport source (output valid, mode, first, x_value, y_value, z_value,
                   x_finite, y_finite, z_finite, input ready);
   modport sink   (input valid, mode, first, x_value, y_value, z_value,
                   x_finite, y_finite, z_finite, output ready);
endinterface

interface mmn_rsp_if import mmn_pkg::*; ();
   logic       valid;
   logic       ready;
   result_type x_result;
   result_type y_result;
   result_type z_result;
   logic       x_valid;
   logic       y_valid;
   logic       z_valid;

   modport source (output valid, x_result, y_result, z_result,
                   x_valid, y_valid, z_valid, input ready);
   modport sink   (input valid, x_result, y_result, z_result,
                   x_valid, y_valid, z_valid, output ready);
endinterface

interface mmn_csr_if import mmn_pkg::*; ();
   logic     valid;
   logic     ready;
   kind_type transform_kind;

   modport source (output valid, transform_kind, input ready);
   modport sink   (input valid, transform_kind, output ready);
endinterface

>>> rtl/masked_minmax_axis_normalizer_top.sv
// Top level of the masked min-max axis normalizer.
// Depends on mmn_pkg, mmn_if, mmn_ctrl and mmn_datapath.
//
// Usage: the host streams a three-channel position map twice on req_ch.
//  - Measure pass (mode 0): per channel, the minimum and maximum over finite
//    values are tracked; first = 1 clears them before the item. No result.
//  - Apply pass (mode 1): one result item on rsp_ch per request item,
//    according to transform_kind: raw, value minus minimum, or
//    (value - min) / (max - min) in Q1.16, rounded to nearest. Non-finite
//    values pass through unchanged with their flag cleared.
// csr_ch writes transform_kind; it is always ready and must only be written
// while the block is idle.
// Sequence: a measure item is accepted, then its extremes are updated. An
// apply item goes through accept, setup, 17 restoring divider steps (the
// 17th is the rounding bit) and the result load. The three channels divide
// in parallel; the divider step count sets the rate. A new item is taken
// only in idle. The result appears in the cycle after the load.
// Stall: the result sits in an output register; the next item is taken
// while it waits, and only the final load stalls until the slot frees.
// Reset: kind goes to raw, extremes are marked empty (min = max = 0).
module masked_minmax_axis_normalizer_top import mmn_pkg::*; (
   input logic     clock,
   input logic     reset,
   mmn_req_if.sink   req_ch,
   mmn_rsp_if.source rsp_ch,
   mmn_csr_if.sink   csr_ch
);

   dp_cmd_type cmd;

   // config writes go straight into the kind register
   assign csr_ch.ready = 1'b1;

   mmn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   mmn_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_write (csr_ch.valid),
      .csr_kind  (csr_ch.transform_kind),
      .first_in  (req_ch.first),
      .x_value   (req_ch.x_value),
      .y_value   (req_ch.y_value),
      .z_value   (req_ch.z_value),
      .x_finite  (req_ch.x_finite),
      .y_finite  (req_ch.y_finite),
      .z_finite  (req_ch.z_finite),
      .x_result  (rsp_ch.x_result),
      .y_result  (rsp_ch.y_result),
      .z_result  (rsp_ch.z_result),
      .x_valid   (rsp_ch.x_valid),
      .y_valid   (rsp_ch.y_valid),
      .z_valid   (rsp_ch.z_valid)
   );

endmodule

>>> rtl/mmn_ctrl.sv
// Sequencer of the normalizer: accepts items, steps the divider, owns the
// result valid flag. Depends on mmn_pkg.
module mmn_ctrl import mmn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_mode,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_MEASURE = 3'd1;
   localparam logic [2:0] S_PREP    = 3'd2;
   localparam logic [2:0] S_DIV     = 3'd3;
   localparam logic [2:0] S_FINISH  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_mode == MODE_APPLY) ? S_PREP : S_MEASURE;
            end
         end
         S_MEASURE: begin
            cmd.measure = 1'b1;
            state_in    = S_IDLE;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/mmn_lane.sv
// One channel of the datapath: extremes, restoring divider, result register.
// Depends on mmn_pkg.
module mmn_lane import mmn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  dp_cmd_type cmd,
   input  logic       first,
   input  kind_type   kind,
   input  value_type  value_in,
   input  logic       finite_in,
   output result_type result,
   output logic       result_finite
);

   localparam int V = VALUE_WIDTH;
   localparam int F = FRACTION_BITS;

   value_type         v_ff, v_in;
   logic              fin_ff, fin_in;
   value_type         mn_ff, mn_in, mx_ff, mx_in;
   logic              seen_ff, seen_in;
   result_type        diff_ff, diff_in;
   logic [V-1:0]      rem_ff, rem_in, rng_ff, rng_in;
   logic [F:0]        quo_ff, quo_in;
   logic              sat_zero_ff, sat_zero_in, sat_one_ff, sat_one_in;
   result_type        res_ff, res_in;
   logic              res_fin_ff, res_fin_in;

   logic              seen_eff;
   value_type         mn_eff, mx_eff;
   result_type        range_w, diff_w;
   logic [V:0]        rem_shl, trial;
   logic              ge;
   logic [F+1:0]      rnd_sum;
   logic [F:0]        norm_q;
   logic [WIDE_W-1:0] norm_wide;

   assign seen_eff = seen_ff && !first;
   assign mn_eff   = seen_ff ? mn_ff : '0;
   assign mx_eff   = seen_ff ? mx_ff : '0;
   assign range_w  = {mx_eff[V-1], mx_eff} - {mn_eff[V-1], mn_eff};
   assign diff_w   = {v_ff[V-1], v_ff} - {mn_eff[V-1], mn_eff};

   // one restoring step per cycle
   assign rem_shl = {rem_ff, 1'b0};
   assign ge      = (rem_shl >= {1'b0, rng_ff});
   assign trial   = rem_shl - {1'b0, rng_ff};

   // last quotient bit is the half bit: round to nearest, ties up
   assign rnd_sum   = {1'b0, quo_ff} + (F + 2)'(1);
   always_comb begin
      if (sat_zero_ff) begin
         norm_q = '0;
      end else if (sat_one_ff) begin
         norm_q = (F + 1)'(1) << F;
      end else begin
         norm_q = rnd_sum[F+1:1];
      end
   end
   assign norm_wide = WIDE_W'(norm_q);

   always_comb begin
      v_in        = v_ff;
      fin_in      = fin_ff;
      mn_in       = mn_ff;
      mx_in       = mx_ff;
      seen_in     = seen_ff;
      diff_in     = diff_ff;
      rem_in      = rem_ff;
      rng_in      = rng_ff;
      quo_in      = quo_ff;
      sat_zero_in = sat_zero_ff;
      sat_one_in  = sat_one_ff;
      res_in      = res_ff;
      res_fin_in  = res_fin_ff;

      if (cmd.load) begin
         v_in   = value_in;
         fin_in = finite_in;
      end

      if (cmd.measure) begin
         if (fin_ff) begin
            seen_in = 1'b1;
            if (!seen_eff) begin
               mn_in = v_ff;
               mx_in = v_ff;
            end else begin
               if (v_ff < mn_ff) mn_in = v_ff;
               if (v_ff > mx_ff) mx_in = v_ff;
            end
         end else if (first) begin
            seen_in = 1'b0;
         end
      end

      if (cmd.prep) begin
         diff_in     = diff_w;
         rem_in      = diff_w[V-1:0];
         rng_in      = range_w[V-1:0];
         quo_in      = '0;
         // below the minimum (negative difference) or at it gives zero
         sat_zero_in = (range_w == '0) || diff_w[V] || (diff_w == '0);
         sat_one_in  = (diff_w >= range_w);
      end

      if (cmd.step) begin
         rem_in = ge ? trial[V-1:0] : rem_shl[V-1:0];
         quo_in = (F + 1)'({quo_ff, ge});
      end

      if (cmd.finish) begin
         res_fin_in = fin_ff;
         if (!fin_ff) begin
            res_in = {v_ff[V-1], v_ff};
         end else begin
            case (kind)
               KIND_SHIFT: res_in = diff_ff;
               KIND_NORM:  res_in = norm_wide[V:0];
               default:    res_in = {v_ff[V-1], v_ff};
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      fin_ff      <= fin_in;
      mn_ff       <= mn_in;
      mx_ff       <= mx_in;
      diff_ff     <= diff_in;
      rem_ff      <= rem_in;
      rng_ff      <= rng_in;
      quo_ff      <= quo_in;
      sat_zero_ff <= sat_zero_in;
      sat_one_ff  <= sat_one_in;
      res_ff      <= res_in;
      res_fin_ff  <= res_fin_in;
   end

   assign result        = res_ff;
   assign result_finite = res_fin_ff;

endmodule

>>> rtl/mmn_datapath.sv
// Datapath: transform kind register, first flag, three channel lanes.
// Depends on mmn_pkg and mmn_lane.
module mmn_datapath import mmn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  dp_cmd_type cmd,
   input  logic       csr_write,
   input  kind_type   csr_kind,
   input  logic       first_in,
   input  value_type  x_value,
   input  value_type  y_value,
   input  value_type  z_value,
   input  logic       x_finite,
   input  logic       y_finite,
   input  logic       z_finite,
   output result_type x_result,
   output result_type y_result,
   output result_type z_result,
   output logic       x_valid,
   output logic       y_valid,
   output logic       z_valid
);

   kind_type kind_ff, kind_in;
   logic     first_ff, first_in_d;

   assign kind_in    = csr_write ? csr_kind : kind_ff;
   assign first_in_d = cmd.load ? first_in : first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_RAW;
      end else begin
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in_d;
   end

   mmn_lane u_lane_x (
      .clock(clock), .reset(reset), .cmd(cmd), .first(first_ff), .kind(kind_ff),
      .value_in(x_value), .finite_in(x_finite),
      .result(x_result), .result_finite(x_valid)
   );

   mmn_lane u_lane_y (
      .clock(clock), .reset(reset), .cmd(cmd), .first(first_ff), .kind(kind_ff),
      .value_in(y_value), .finite_in(y_finite),
      .result(y_result), .result_finite(y_valid)
   );

   mmn_lane u_lane_z (
      .clock(clock), .reset(reset), .cmd(cmd), .first(first_ff), .kind(kind_ff),
      .value_in(z_value), .finite_in(z_finite),
      .result(z_result), .result_finite(z_valid)
   );

endmodule

>>> rtl/mmn_checker.sv
// Port-level assertions for the normalizer top, attached by bind.
// Depends on mmn_pkg and masked_minmax_axis_normalizer_top.
module mmn_checker import mmn_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input result_type x_result,
   input logic       x_valid,
   input logic       csr_ready
);

   // a result held back by the receiver stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(x_result) && $stable(x_valid))
      else $error("result payload changed while stalled");

   // an accepted item takes the block out of idle, so ready drops after each accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted on consecutive cycles");

   // config port never back-pressures
   assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("config port not ready");

endmodule

bind masked_minmax_axis_normalizer_top mmn_checker u_mmn_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .x_result  (rsp_ch.x_result),
   .x_valid   (rsp_ch.x_valid),
   .csr_ready (csr_ch.ready)
);

>>> test/mmn_result_checker.sv
// Result checker for the masked min-max axis normalizer: watches the three channels,
// predicts every result item and compares it field by field.
// Depends on mmn_pkg and the channel interfaces in mmn_if.
module mmn_result_checker import mmn_pkg::*; (
   input  logic clock,
   input  logic reset,
   mmn_req_if   req_ch,
   mmn_rsp_if   rsp_ch,
   mmn_csr_if   csr_ch,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      result_type [CHANNELS-1:0] value;
      logic [CHANNELS-1:0]       valid;
   } norm_pixel_type;

   kind_type       kind;
   value_type      axis_min [CHANNELS];
   value_type      axis_max [CHANNELS];
   logic           axis_seen [CHANNELS];
   norm_pixel_type expected_pixels [$];
   int             pixels_checked;
   string          axis_tag [CHANNELS] = '{"x", "y", "z"};

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] pixel %0d: %s got %0d want %0d", $realtime, pixels_checked, what,
               got, want);
      fail_count++;
   endtask

   function automatic void clear_extremes();
      for (int c = 0; c < CHANNELS; c++) begin
         axis_min[c]  = '0;
         axis_max[c]  = '0;
         axis_seen[c] = 1'b0;
      end
   endfunction

   // (v - lo) / (hi - lo) in Q1.FRACTION_BITS, saturated, rounded half up
   function automatic result_type normalize_axis(longint v, longint lo, longint hi);
      longint               span;
      longint               diff;
      longint unsigned      rem;
      longint unsigned      quo;
      span = hi - lo;
      diff = v - lo;
      quo  = 0;
      if (span <= 0 || diff <= 0)
         return '0;
      if (diff >= span)
         return result_type'(longint'(1) << FRACTION_BITS);
      rem = unsigned'(diff);
      for (int i = 0; i < FRACTION_BITS; i++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= unsigned'(span)) begin
            rem = rem - unsigned'(span);
            quo = quo | 1;
         end
      end
      if ((rem << 1) >= unsigned'(span))
         quo = quo + 1;
      return result_type'(quo);
   endfunction

   task automatic take_pixel();
      value_type      v [CHANNELS];
      logic           fin [CHANNELS];
      norm_pixel_type px;
      longint         lo;
      longint         hi;
      longint         val;
      v[0]   = req_ch.x_value;
      v[1]   = req_ch.y_value;
      v[2]   = req_ch.z_value;
      fin[0] = req_ch.x_finite;
      fin[1] = req_ch.y_finite;
      fin[2] = req_ch.z_finite;
      if (req_ch.mode == MODE_MEASURE) begin
         if (req_ch.first)
            clear_extremes();
         for (int c = 0; c < CHANNELS; c++) begin
            if (fin[c]) begin
               if (!axis_seen[c]) begin
                  axis_min[c]  = v[c];
                  axis_max[c]  = v[c];
                  axis_seen[c] = 1'b1;
               end else begin
                  if (v[c] < axis_min[c]) axis_min[c] = v[c];
                  if (v[c] > axis_max[c]) axis_max[c] = v[c];
               end
            end
         end
      end else begin
         for (int c = 0; c < CHANNELS; c++) begin
            lo  = axis_seen[c] ? longint'(axis_min[c]) : 64'sd0;
            hi  = axis_seen[c] ? longint'(axis_max[c]) : 64'sd0;
            val = longint'(v[c]);
            px.value[c] = result_type'(val);
            if (fin[c]) begin
               if (kind == KIND_SHIFT)
                  px.value[c] = result_type'(val - lo);
               else if (kind == KIND_NORM)
                  px.value[c] = normalize_axis(val, lo, hi);
            end
            px.valid[c] = fin[c];
         end
         expected_pixels.push_back(px);
      end
   endtask

   task automatic check_pixel();
      norm_pixel_type want;
      result_type     got [CHANNELS];
      logic           got_valid [CHANNELS];
      got[0]       = rsp_ch.x_result;
      got[1]       = rsp_ch.y_result;
      got[2]       = rsp_ch.z_result;
      got_valid[0] = rsp_ch.x_valid;
      got_valid[1] = rsp_ch.y_valid;
      got_valid[2] = rsp_ch.z_valid;
      if (expected_pixels.size() == 0) begin
         report_mismatch("result item with none expected", longint'(got[0]), 0);
         return;
      end
      want = expected_pixels.pop_front();
      for (int c = 0; c < CHANNELS; c++) begin
         if (got[c] !== want.value[c])
            report_mismatch({axis_tag[c], "_result"}, longint'(got[c]),
                            longint'(want.value[c]));
         if (got_valid[c] !== want.valid[c])
            report_mismatch({axis_tag[c], "_valid"}, longint'(got_valid[c]),
                            longint'(want.valid[c]));
      end
      pixels_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kind = KIND_RAW;
         clear_extremes();
         expected_pixels.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready)
            kind = csr_ch.transform_kind;
         if (req_ch.valid && req_ch.ready)
            take_pixel();
         if (rsp_ch.valid && rsp_ch.ready)
            check_pixel();
      end
      pending = expected_pixels.size();
   end

endmodule

>>> test/testbench.sv
// Top of the masked min-max axis normalizer testbench: clock, reset, stimulus and verdict.
// Depends on mmn_pkg, mmn_if, the normalizer top and mmn_result_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mmn_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int          HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int          DRAIN_WAIT  = 30;    // block latency plus margin
   localparam int          PHASES      = 16;
   localparam int          PHASE_ITEMS = 104;
   // kind code 3 is unused by the block and must behave as raw
   localparam kind_type    KIND_SPARE  = 2'd3;
   localparam value_type   VALUE_MIN   = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam value_type   VALUE_MAX   = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   logic clock;
   logic reset;

   mmn_req_if req_ch ();
   mmn_rsp_if rsp_ch ();
   mmn_csr_if csr_ch ();

   int          fail_count;
   int          pending;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_requests  = 0;   // bumped by stimulus, served by receiver
   int          hold_served;
   int          hold_left;
   int          items_sent     = 0;
   int unsigned cycle_count;

   masked_minmax_axis_normalizer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   mmn_result_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Result receiver. Random stalls per the current phase; a pending hold-off
   // request forces ready low for HOLD_CYCLES so the block backs up and
   // stalls its input while the sender keeps offering items.
   initial begin
      rsp_ch.ready = 1'b0;
      hold_served  = 0;
      hold_left    = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_served != hold_requests) begin
            hold_left = HOLD_CYCLES;
            hold_served++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Offer one pixel item; fin[0] is x, fin[1] is y, fin[2] is z.
   // Returns right after the accepting edge with valid still high, so that
   // back-to-back items never drop valid in between.
   task automatic send_pixel(input logic mode, input logic first, input value_type x,
                             input value_type y, input value_type z, input logic [2:0] fin);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.mode     <= mode;
      req_ch.first    <= first;
      req_ch.x_value  <= x;
      req_ch.y_value  <= y;
      req_ch.z_value  <= z;
      req_ch.x_finite <= fin[0];
      req_ch.y_finite <= fin[1];
      req_ch.z_finite <= fin[2];
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Drop valid, wait for every expected result, then let a measure item
   // still in flight (no result of its own) finish before anything else.
   task automatic drain_block();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // Only called with the block drained.
   task automatic write_kind(input kind_type kind);
      @(negedge clock);
      csr_ch.valid          <= 1'b1;
      csr_ch.transform_kind <= kind;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Mostly values clustered in [base, base + spread]; widen stretches the
   // window past both ends so apply items also land outside the extremes.
   function automatic value_type frame_value(input value_type base, input int unsigned spread,
                                             input bit widen);
      int unsigned offset;
      offset = widen ? $urandom_range(spread + spread / 4) - spread / 8
                     : $urandom_range(spread);
      case ($urandom_range(11))
         0:       frame_value = value_type'($urandom);
         1:       frame_value = VALUE_MIN;
         2:       frame_value = VALUE_MAX;
         3:       frame_value = '0;
         default: frame_value = base + value_type'(offset);
      endcase
   endfunction

   // One frame: a measure pass, then an apply pass over the same kind of data.
   // A few frames skip the measure pass or keep old extremes (no first flag),
   // a few channels stay non-finite through the measure pass (never-seen case), and some
   // measure items are mixed into the apply pass as noise.
   task automatic run_frame(input bit hold);
      value_type   base [CHANNELS];
      int unsigned spread [CHANNELS];
      bit          dead [CHANNELS];
      value_type   v [CHANNELS];
      logic [2:0]  fin;
      logic        first;
      int          n_measure;
      int          n_apply;
      n_measure = $urandom_range(10);
      n_apply   = $urandom_range(1, 12);
      for (int c = 0; c < CHANNELS; c++) begin
         base[c] = value_type'($urandom);
         dead[c] = ($urandom_range(9) == 0);
         case ($urandom_range(5))
            0:       spread[c] = 0;           // zero range
            1:       spread[c] = 3;
            2:       spread[c] = 255;
            3:       spread[c] = 65535;
            4:       spread[c] = 32'h00FF_FFFF;
            default: spread[c] = 32'h7FFF_FFFF;
         endcase
      end
      for (int i = 0; i < n_measure; i++) begin
         for (int c = 0; c < CHANNELS; c++) begin
            v[c]   = frame_value(base[c], spread[c], 1'b0);
            fin[c] = !dead[c] && ($urandom_range(99) < 85);
         end
         first = (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0);
         send_pixel(MODE_MEASURE, first, v[0], v[1], v[2], fin);
      end
      if (hold)
         hold_requests++;
      for (int i = 0; i < n_apply; i++) begin
         for (int c = 0; c < CHANNELS; c++) begin
            v[c]   = frame_value(base[c], spread[c], 1'b1);
            fin[c] = dead[c] ? ($urandom_range(3) == 0) : ($urandom_range(99) < 85);
         end
         if ($urandom_range(19) == 0)
            send_pixel(MODE_MEASURE, 1'($urandom_range(1)), v[0], v[1], v[2], fin);
         else
            send_pixel(MODE_APPLY, 1'($urandom_range(1)), v[0], v[1], v[2], fin);
      end
   endtask

   initial begin
      int target;
      // every input known from time zero
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.mode           = MODE_MEASURE;
      req_ch.first          = 1'b0;
      req_ch.x_value        = '0;
      req_ch.y_value        = '0;
      req_ch.z_value        = '0;
      req_ch.x_finite       = 1'b0;
      req_ch.y_finite       = 1'b0;
      req_ch.z_finite       = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.transform_kind = KIND_RAW;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // raw kind after reset, channels never measured, extremes pass through
      send_pixel(MODE_APPLY, 1'b0, VALUE_MIN, VALUE_MAX, '0, 3'b101);
      drain_block();
      write_kind(KIND_NORM);
      // never-seen channels: zero range gives 0; first flag on apply ignored
      send_pixel(MODE_APPLY, 1'b1, 5, VALUE_MIN, VALUE_MAX, 3'b111);
      // full-scale extremes on x and z, y only ever sees 0
      send_pixel(MODE_MEASURE, 1'b1, VALUE_MIN, '0, VALUE_MAX, 3'b111);
      send_pixel(MODE_MEASURE, 1'b0, VALUE_MAX, 7, VALUE_MIN, 3'b101);
      // non-finite values never move the extremes
      send_pixel(MODE_MEASURE, 1'b0, 123, VALUE_MAX, -1, 3'b000);
      send_pixel(MODE_APPLY, 1'b0, VALUE_MIN, '0, VALUE_MAX, 3'b111);
      send_pixel(MODE_APPLY, 1'b0, VALUE_MAX, -9, VALUE_MIN, 3'b101);
      send_pixel(MODE_APPLY, 1'b1, '0, '0, '0, 3'b111);
      drain_block();
      write_kind(KIND_SHIFT);
      // widest shifted difference, and non-finite passthrough under shift
      send_pixel(MODE_APPLY, 1'b0, VALUE_MAX, VALUE_MIN, VALUE_MIN, 3'b111);
      send_pixel(MODE_APPLY, 1'b0, 77, 77, 77, 3'b010);
      drain_block();
      write_kind(KIND_SPARE);
      send_pixel(MODE_APPLY, 1'b0, -5, 6, VALUE_MAX, 3'b111);
      drain_block();
      write_kind(KIND_NORM);
      // x range 3 (thirds), y range 2^17 (exact rounding tie), z zero range
      send_pixel(MODE_MEASURE, 1'b1, 10, '0, -100, 3'b111);
      send_pixel(MODE_MEASURE, 1'b0, 13, 32'h0002_0000, -100, 3'b111);
      send_pixel(MODE_APPLY, 1'b0, 11, 1, -100, 3'b111);
      send_pixel(MODE_APPLY, 1'b0, 12, 32'h0001_FFFF, 55, 3'b111);
      // below the minimum saturates to 0, above the maximum to 1.0
      send_pixel(MODE_APPLY, 1'b0, 5, -1, 20, 3'b111);
      send_pixel(MODE_APPLY, 1'b0, 20, 32'h0003_0000, VALUE_MAX, 3'b111);

      // ---- random part ----
      // Each phase drains the block (the sender pauses until every result is
      // back), picks a kind, then sets the idle pattern:
      //   0: no idling, 1: sender idle half the time,
      //   2: receiver stalls half the time, 3: both idle 10 percent.
      // Phase 4 also carries the long receiver hold-off.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_block();
         write_kind(kind_type'((phase + phase / 4) % 3));
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         target = items_sent + PHASE_ITEMS;
         run_frame(phase == 4);
         while (items_sent < target)
            run_frame(1'b0);
      end

      drain_block();
      if (fail_count == 0 && pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
